>>> hw/rtl/led_scanner_fade_debounce_assert.svh
// ----------------------------------------------------------------------------
// led_scanner_fade_debounce_assert.svh
// Assertion macros used by the LED scanner RTL.
// ----------------------------------------------------------------------------
`ifndef LED_SCANNER_FADE_DEBOUNCE_ASSERT_SVH
`define LED_SCANNER_FADE_DEBOUNCE_ASSERT_SVH

// Concurrent check, muted while reset is asserted.
`define LSFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check, also live during reset.
`define LSFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lsfd_pkg.sv
// ----------------------------------------------------------------------------
// lsfd_pkg
// Types and constants for the LED scanner with fade and button debounce.
// ----------------------------------------------------------------------------
package lsfd_pkg;

  localparam int unsigned NumLeds   = 8;
  localparam int unsigned LitLevels = 5;
  localparam int unsigned LevelW    = 3;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgW      = 8;
  localparam int unsigned CfgIdxW   = 1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgShiftPeriod = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounce    = 1'd1;

  // Register reset values
  localparam logic [CfgW-1:0] ShiftPeriodRst = 8'd25;
  localparam logic [CfgW-1:0] DebounceRst    = 8'd4;

  localparam logic [LevelW-1:0] LastPhase = LevelW'(LitLevels - 1);

  // One brightness slot: valid flag and level
  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] level;
  } slot_t;

  typedef slot_t [NumLeds-1:0] ring_t;

endpackage

>>> hw/rtl/led_scanner_fade_debounce.sv
// ----------------------------------------------------------------------------
// led_scanner_fade_debounce
// Sweeping LED bar with PWM fade tail, switch override and button debounce.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one timer tick: button level, switch levels and a
//   debounce enable. Each accepted word yields exactly one output word with
//   the LED drive pattern and a one-tick debounce release event.
//   Both channels use valid/stall; a word moves when valid is high and stall
//   is low. Configuration (shift period, debounce threshold) is written
//   through cfg_we_i / cfg_index_i / cfg_wdata_i while the block is idle.
// Throughput:
//   The output word is registered. One word per cycle is sustained while
//   out_stall_i is low; ring, phase and debounce updates are all done by
//   the logic feeding the output register.
// Stall:
//   An output register plus one skid entry decouple the sides; input stall
//   rises only when both hold words.
// Reset:
//   Ring holds levels 0..4 in the first forward slots, counters are zero,
//   registers take their defaults and no output word is pending.
// ----------------------------------------------------------------------------
module led_scanner_fade_debounce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              button_pressed_i,
  input  logic [7:0]                        switches_i,
  input  logic                              debounce_enable_i,
  // output words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        led_pattern_o,
  output logic                              debounce_event_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [lsfd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lsfd_pkg::CfgW-1:0]         cfg_wdata_i
);

  `include "led_scanner_fade_debounce_assert.svh"

  // Configuration registers
  logic [lsfd_pkg::CfgW-1:0] shift_period_q;
  logic [lsfd_pkg::CfgW-1:0] debounce_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_period_q   <= lsfd_pkg::ShiftPeriodRst;
      debounce_ticks_q <= lsfd_pkg::DebounceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lsfd_pkg::CfgShiftPeriod: shift_period_q   <= cfg_wdata_i;
        lsfd_pkg::CfgDebounce:    debounce_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake
  logic in_accept;
  logic out_valid_q, skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;

  // Tick state
  lsfd_pkg::ring_t                  fwd_q, fwd_d, ret_q, ret_d;
  logic [lsfd_pkg::LevelW-1:0]      phase_q, phase_d;
  logic [lsfd_pkg::CountW-1:0]      shift_cnt_q, shift_cnt_d, shift_inc;
  logic [lsfd_pkg::CountW-1:0]      held_q, held_d;
  logic                             rotate;
  logic [7:0]                       res_leds;
  logic                             res_event;

  always_comb begin
    // PWM phase wraps at the number of lit levels
    phase_d = (phase_q == lsfd_pkg::LastPhase) ? '0 : phase_q + 1'b1;

    // Shift counter and ring rotation
    shift_inc   = shift_cnt_q + 1'b1;
    rotate      = (shift_inc >= shift_period_q);
    shift_cnt_d = rotate ? '0 : shift_inc;
    fwd_d       = fwd_q;
    ret_d       = ret_q;
    if (rotate) begin
      for (int i = 1; i < lsfd_pkg::NumLeds; i++) begin
        fwd_d[i]   = fwd_q[i-1];
        ret_d[i-1] = ret_q[i];
      end
      fwd_d[0]                    = ret_q[0];
      ret_d[lsfd_pkg::NumLeds-1]  = fwd_q[lsfd_pkg::NumLeds-1];
    end

    // Button debounce
    held_d    = held_q;
    res_event = 1'b0;
    if (debounce_enable_i) begin
      if (button_pressed_i) begin
        if (held_q != debounce_ticks_q) held_d = held_q + 1'b1;
      end else begin
        res_event = (held_q == debounce_ticks_q);
        held_d    = '0;
      end
    end

    // LED pattern from updated phase and ring, switches on top
    for (int i = 0; i < 8; i++) begin
      res_leds[i] = switches_i[i] ||
                    (fwd_d[i].valid && (fwd_d[i].level >= phase_d)) ||
                    (ret_d[i].valid && (ret_d[i].level >= phase_d));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lsfd_pkg::NumLeds; i++) begin
        fwd_q[i].valid <= (i < lsfd_pkg::LitLevels);
        fwd_q[i].level <= (i < lsfd_pkg::LitLevels) ? lsfd_pkg::LevelW'(i) : '0;
        ret_q[i]       <= '0;
      end
      phase_q     <= '0;
      shift_cnt_q <= '0;
      held_q      <= '0;
    end else if (in_accept) begin
      fwd_q       <= fwd_d;
      ret_q       <= ret_d;
      phase_q     <= phase_d;
      shift_cnt_q <= shift_cnt_d;
      held_q      <= held_d;
    end
  end

  // Output register with one skid entry
  logic       out_pop, main_free;
  logic [7:0] out_leds_q, skid_leds_q;
  logic       out_event_q, skid_event_q;

  assign out_pop   = out_valid_q && !out_stall_i;
  assign main_free = !out_valid_q || out_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (main_free) begin
        out_valid_q  <= skid_valid_q || in_accept;
        skid_valid_q <= 1'b0;
      end else if (in_accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      if (skid_valid_q) begin
        out_leds_q  <= skid_leds_q;
        out_event_q <= skid_event_q;
      end else if (in_accept) begin
        out_leds_q  <= res_leds;
        out_event_q <= res_event;
      end
    end else if (in_accept) begin
      skid_leds_q  <= res_leds;
      skid_event_q <= res_event;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_pattern_o    = out_leds_q;
  assign debounce_event_o = out_event_q;

  // Valid flags of all slots, for checking
  logic [2*lsfd_pkg::NumLeds-1:0] slot_valid_vec;
  always_comb begin
    for (int i = 0; i < lsfd_pkg::NumLeds; i++) begin
      slot_valid_vec[i]                    = fwd_q[i].valid;
      slot_valid_vec[i+lsfd_pkg::NumLeds]  = ret_q[i].valid;
    end
  end

  // Assertions
  `LSFD_ASSERT_ALWAYS(a_skid_needs_main, clk_i, skid_valid_q |-> out_valid_q,
    "skid word present without output word")
  `LSFD_ASSERT(a_skid_fill, clk_i, rst_ni,
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i),
    "skid filled while output register was free")
  `LSFD_ASSERT(a_lit_slots, clk_i, rst_ni,
    $countones(slot_valid_vec) == lsfd_pkg::LitLevels,
    "ring rotation lost or duplicated a lit slot")
  `LSFD_ASSERT(a_phase_range, clk_i, rst_ni, phase_q <= lsfd_pkg::LastPhase,
    "PWM phase out of range")

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED scanner with fade tail and button debounce.
// A directed table of timer ticks runs first, then button press sequences with
// random length, enable noise and switch patterns under several register
// settings. A local model of the ring, PWM phase and debounce counter predicts
// each output word that no typed row gives. Both sides idle at random, and the
// receiver holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned IdlePct     = 25;
  localparam int unsigned HoldCycles  = 48;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned NumDirected = 21;

  // One tick for the input side; typed rows carry their own expected word
  typedef struct packed {
    logic       btn;
    logic [7:0] sw;
    logic       en;
    logic       typed;
    logic [7:0] led;
    logic       pulse;
  } tick_row_t;

  typedef struct packed {
    logic [7:0] pattern;
    logic       release_pulse;
  } led_word_t;

  // Directed ticks, reset settings (period 25, threshold 4)
  localparam tick_row_t DirectedTicks [NumDirected] = '{
    '{1'b0, 8'h00, 1'b0, 1'b1, 8'h1E, 1'b0},  // phase 1, dark empty slots
    '{1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0},  // all switches on
    '{1'b1, 8'h00, 1'b1, 1'b1, 8'h18, 1'b0},  // press starts
    '{1'b1, 8'h00, 1'b1, 1'b1, 8'h10, 1'b0},
    '{1'b1, 8'h00, 1'b1, 1'b1, 8'h1F, 1'b0},  // phase back to zero
    '{1'b1, 8'h00, 1'b1, 1'b1, 8'h1E, 1'b0},  // count reaches threshold
    '{1'b1, 8'h00, 1'b1, 1'b1, 8'h1C, 1'b0},  // count holds
    '{1'b0, 8'h00, 1'b1, 1'b1, 8'h18, 1'b1},  // release fires event
    '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b1, 8'hAA, 1'b0, 1'b0, 8'h00, 1'b0},  // debounce disabled
    '{1'b0, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b1, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0},  // press with enable toggling
    '{1'b1, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b1, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b1, 8'h7F, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, 8'hFE, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b1, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b1, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},  // short press, no event
    '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0}
  };

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic                         btn_in    = 1'b0;
  logic [7:0]                   sw_in     = 8'h00;
  logic                         en_in     = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [7:0]                   led_out;
  logic                         pulse_out;
  logic                         cfg_we    = 1'b0;
  logic [lsfd_pkg::CfgIdxW-1:0] cfg_idx   = lsfd_pkg::CfgShiftPeriod;
  logic [lsfd_pkg::CfgW-1:0]    cfg_data  = '0;

  // Scanner model state and register copies
  lsfd_pkg::ring_t fwd_ring;
  lsfd_pkg::ring_t ret_ring;
  logic [2:0]  phase;
  logic [7:0]  shift_cnt;
  logic [7:0]  held_cnt;
  logic [7:0]  period_reg;
  logic [7:0]  thr_reg;

  led_word_t   pending_words[$];
  int unsigned err_count     = 0;
  int unsigned items_sent    = 0;
  int unsigned gap_pct       = IdlePct;
  int unsigned hold_requests = 0;

  led_scanner_fade_debounce u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .button_pressed_i  (btn_in),
    .switches_i        (sw_in),
    .debounce_enable_i (en_in),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .led_pattern_o     (led_out),
    .debounce_event_o  (pulse_out),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_idx),
    .cfg_wdata_i       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model reset: levels 0..LitLevels-1 in the first forward slots
  function automatic void reset_model();
    for (int i = 0; i < lsfd_pkg::NumLeds; i++) begin
      fwd_ring[i] = '0;
      ret_ring[i] = '0;
      if (i < lsfd_pkg::LitLevels) begin
        fwd_ring[i].valid = 1'b1;
        fwd_ring[i].level = lsfd_pkg::LevelW'(i);
      end
    end
    phase      = '0;
    shift_cnt  = '0;
    held_cnt   = '0;
    period_reg = lsfd_pkg::ShiftPeriodRst;
    thr_reg    = lsfd_pkg::DebounceRst;
  endfunction

  // One timer tick: advance phase, ring and debounce, return the LED word
  function automatic led_word_t scan_tick(input logic btn, input logic [7:0] sw,
                                          input logic en);
    led_word_t       res;
    lsfd_pkg::slot_t carry;
    res   = '0;
    phase = (phase == lsfd_pkg::LastPhase) ? '0 : phase + 1'b1;
    shift_cnt = shift_cnt + 1'b1;
    if (shift_cnt >= period_reg) begin
      shift_cnt = '0;
      carry     = fwd_ring[lsfd_pkg::NumLeds-1];
      fwd_ring  = {fwd_ring[lsfd_pkg::NumLeds-2:0], ret_ring[0]};
      ret_ring  = {carry, ret_ring[lsfd_pkg::NumLeds-1:1]};
    end
    if (en) begin
      if (btn) begin
        if (held_cnt != thr_reg) held_cnt = held_cnt + 1'b1;
      end else begin
        res.release_pulse = (held_cnt == thr_reg);
        held_cnt = '0;
      end
    end
    for (int i = 0; i < lsfd_pkg::NumLeds; i++) begin
      res.pattern[i] = (fwd_ring[i].valid && fwd_ring[i].level >= phase) ||
                       (ret_ring[i].valid && ret_ring[i].level >= phase);
    end
    res.pattern = res.pattern | sw;
    return res;
  endfunction

  function automatic tick_row_t random_tick(input logic btn, input logic en);
    tick_row_t row;
    row     = '0;
    row.btn = btn;
    row.en  = en;
    row.sw  = ($urandom_range(2) == 0) ? 8'($urandom) : 8'h00;
    return row;
  endfunction

  // Offer one word, wait for the handshake, queue its expectation.
  // Entered and left at a falling edge.
  task automatic send_tick(input tick_row_t row);
    led_word_t want;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    btn_in   <= row.btn;
    sw_in    <= row.sw;
    en_in    <= row.en;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = scan_tick(row.btn, row.sw, row.en);
    if (row.typed) begin
      want.pattern       = row.led;
      want.release_pulse = row.pulse;
    end
    @(negedge clk);
    pending_words.push_back(want);
    items_sent++;
  endtask

  // Stop offering and wait until every word is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers are written back to back while the block is idle
  task automatic set_config(input logic [7:0] period, input logic [7:0] thr);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= lsfd_pkg::CfgShiftPeriod;
    cfg_data <= period;
    @(negedge clk);
    cfg_idx  <= lsfd_pkg::CfgDebounce;
    cfg_data <= thr;
    @(negedge clk);
    cfg_we   <= 1'b0;
    period_reg = period;
    thr_reg    = thr;
  endtask

  // Hold the button for len ticks, then optionally release it
  task automatic button_run(input int unsigned len, input bit release_after,
                            input bit noisy);
    for (int k = 0; k < len; k++)
      send_tick(random_tick(1'b1, noisy ? ($urandom_range(9) != 0) : 1'b1));
    if (release_after) send_tick(random_tick(1'b0, 1'b1));
  endtask

  // Mostly press/release sequences, some loose ticks
  task automatic random_runs(input int unsigned budget);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < budget) begin
      case ($urandom_range(9)) inside
        [0:4]: button_run($urandom_range(thr_reg + 2), 1'b1, $urandom_range(3) == 0);
        [5:7]: button_run(thr_reg + $urandom_range(1), 1'b1, 1'b0);
        default: begin
          repeat ($urandom_range(1, 4))
            send_tick(random_tick(1'($urandom_range(1)), 1'($urandom_range(1))));
        end
      endcase
    end
  endtask

  // Stimulus sequence
  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DirectedTicks[r]) send_tick(DirectedTicks[r]);
    random_runs(50);

    // fastest rotation, no idling on either side
    gap_pct = 0;
    set_config(8'd1, 8'd1);
    random_runs(60);
    gap_pct = IdlePct;

    // slowest settings; leave the button held past the threshold
    set_config(8'd255, 8'd255);
    button_run(256, 1'b1, 1'b0);
    random_runs(60);
    button_run(30, 1'b0, 1'b0);

    // lower period and threshold under the counts; receiver holds off
    set_config(8'd3, 8'd10);
    hold_requests++;
    button_run(5, 1'b1, 1'b0);
    random_runs(80);

    // zero period and zero threshold
    set_config(8'd0, 8'd0);
    random_runs(50);

    repeat (2) begin
      set_config(8'($urandom_range(1, 12)), 8'($urandom_range(1, 8)));
      random_runs(40);
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned holds_served;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
        holds_served++;
      end else begin
        out_stall <= (gap_pct != 0) && ($urandom_range(99) < gap_pct);
      end
    end
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin : check_words
    led_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("word with no expectation: led_pattern=%h debounce_event=%b",
               led_out, pulse_out);
        err_count++;
      end else begin
        want = pending_words.pop_front();
        if (led_out !== want.pattern) begin
          $error("led_pattern: expected %h, got %h", want.pattern, led_out);
          err_count++;
        end
        if (pulse_out !== want.release_pulse) begin
          $error("debounce_event: expected %b, got %b", want.release_pulse, pulse_out);
          err_count++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

endmodule
